// ----- rtl/vre_pkg.sv -----
// Shared types for the vector rank engine: controller states and the
// command/status structs between controller and datapath.
// No dependencies.
package vre_pkg;

	localparam int SAMPLE_W = 32;
	localparam int RANK_W   = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_SWEEP,
		ST_EMIT
	} vre_state_t;

	typedef struct packed {
		logic store;   // write an accepted sample
		logic fetch;   // read the sample under rank, restart the sweep
		logic load;    // latch the sample under rank
		logic sweep;   // issue the next store read for comparison
		logic emit;    // register one result
		logic next_i;  // advance to the next sample
		logic clear;   // end of vector: drop count and flag
	} vre_cmd_t;

	typedef struct packed {
		logic sweep_done;  // every stored sample has been read
		logic last_idx;    // sample under rank is the last stored one
	} vre_stat_t;

endpackage

// ----- rtl/vre_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vre_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/vre_ctrl.sv -----
// Controller state machine of the vector rank engine.
// Depends on vre_pkg for the state type and the command/status structs.
module vre_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               last,
	input  vre_pkg::vre_stat_t stat,
	output vre_pkg::vre_cmd_t  cmd,
	output logic               busy
);

	vre_pkg::vre_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vre_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		busy    = 1'b1;
		case (state_q)
			vre_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.store = 1'b1;
					if (last) begin
						state_d = vre_pkg::ST_FETCH;
					end
				end
			end
			vre_pkg::ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = vre_pkg::ST_LOAD;
			end
			vre_pkg::ST_LOAD: begin
				cmd.load  = 1'b1;
				cmd.sweep = 1'b1;
				state_d   = vre_pkg::ST_SWEEP;
			end
			vre_pkg::ST_SWEEP: begin
				cmd.sweep = 1'b1;
				// the last read returns in this cycle and is counted at this edge
				if (stat.sweep_done) begin
					state_d = vre_pkg::ST_EMIT;
				end
			end
			vre_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.last_idx) begin
					cmd.clear = 1'b1;
					state_d   = vre_pkg::ST_IDLE;
				end else begin
					cmd.next_i = 1'b1;
					state_d    = vre_pkg::ST_FETCH;
				end
			end
			default: begin
				state_d = vre_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/vre_dp.sv -----
// Datapath of the vector rank engine: sample store, fill count, compare
// sweep, rank accumulator and result registers.
// Depends on vre_pkg and vre_ram.
module vre_dp #(
	parameter int MAX_ITEMS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vre_pkg::vre_cmd_t                  cmd,
	output vre_pkg::vre_stat_t                 stat,
	input  logic                               cfg_we,
	input  logic                               cfg_data,
	input  logic signed [vre_pkg::SAMPLE_W-1:0] sample,
	output logic signed [vre_pkg::RANK_W-1:0]   rank,
	output logic                               final_res,
	output logic                               overflow,
	output logic                               strobe
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int AW    = $clog2(MAX_ITEMS);
	localparam int EW    = (CNT_W + 2 > vre_pkg::RANK_W) ? CNT_W + 2 : vre_pkg::RANK_W;

	logic [CNT_W-1:0]                  fill_q;
	logic                              dropped_q;
	logic                              centered_q;
	logic [AW-1:0]                     i_q;
	logic [CNT_W-1:0]                  j_q;
	logic [CNT_W-1:0]                  r_q;
	logic signed [vre_pkg::SAMPLE_W-1:0] v_q;
	logic                              valid_s1;
	logic [AW-1:0]                     jd_s1;

	logic                              full;
	logic                              issue;
	logic                              hit;
	logic [AW-1:0]                     raddr;
	logic [vre_pkg::SAMPLE_W-1:0]      rdata;
	logic signed [vre_pkg::SAMPLE_W-1:0] w;
	logic [EW-1:0]                     plain_val;
	logic [EW-1:0]                     cent_val;

	assign full  = (fill_q == CNT_W'(MAX_ITEMS));
	assign issue = cmd.sweep && (j_q != fill_q);
	assign raddr = cmd.fetch ? i_q : j_q[AW-1:0];
	assign w     = $signed(rdata);
	assign hit   = (w < v_q) || ((w == v_q) && (jd_s1 < i_q));

	assign stat.sweep_done = (j_q == fill_q);
	assign stat.last_idx   = ((CNT_W'(i_q) + CNT_W'(1)) == fill_q);

	vre_ram #(
		.WIDTH (vre_pkg::SAMPLE_W),
		.DEPTH (MAX_ITEMS)
	) u_store (
		.clk   (clk),
		.we    (cmd.store && !full),
		.waddr (fill_q[AW-1:0]),
		.wdata (sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			dropped_q  <= 1'b0;
			centered_q <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			r_q        <= '0;
			valid_s1   <= 1'b0;
			strobe     <= 1'b0;
		end else begin
			if (cfg_we) begin
				centered_q <= cfg_data;
			end
			if (cmd.clear) begin
				fill_q    <= '0;
				dropped_q <= 1'b0;
			end else if (cmd.store) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
			if (cmd.clear) begin
				i_q <= '0;
			end else if (cmd.next_i) begin
				i_q <= i_q + AW'(1);
			end
			if (cmd.fetch) begin
				j_q <= '0;
			end else if (issue) begin
				j_q <= j_q + CNT_W'(1);
			end
			if (cmd.fetch) begin
				r_q <= '0;
			end else if (valid_s1 && hit) begin
				r_q <= r_q + CNT_W'(1);
			end
			valid_s1 <= issue;
			strobe   <= cmd.emit;
		end
	end

	// doubled centered rank: 2r - (n - 1), wrapped to the result width
	assign plain_val = EW'(r_q) + EW'(1);
	assign cent_val  = (EW'(r_q) << 1) - EW'(fill_q) + EW'(1);

	always_ff @(posedge clk) begin
		jd_s1 <= j_q[AW-1:0];
		if (cmd.load) begin
			v_q <= $signed(rdata);
		end
		if (cmd.emit) begin
			rank      <= $signed(centered_q ? cent_val[vre_pkg::RANK_W-1:0]
			                                : plain_val[vre_pkg::RANK_W-1:0]);
			final_res <= stat.last_idx;
			overflow  <= dropped_q;
		end
	end

endmodule

// ----- rtl/vector_rank_engine.sv -----
// Vector rank engine: collects a vector of Q16.16 samples and returns the
// stable rank of each sample in input order.
//
// Input: a transaction is taken at a clock edge with start high and busy low.
// Samples load one per cycle with busy low; up to MAX_ITEMS are stored, any
// further ones are dropped and flag overflow on every result of that vector.
// The transaction with last high ends the vector and raises busy.
// Ranking: for each of the n stored samples the datapath fetches the sample,
// then sweeps the single read port of the sample store over all n entries,
// one compare per cycle. Each result is registered in the emit state after its
// sweep; busy drops in the same cycle that the final result (final_res high)
// is shown.
// Output: each result is valid for one cycle with strobe high; the receiver
// cannot stall, so results never wait.
// Configuration: cfg_we writes cfg_data into the centered mode bit
// (0: 1-based ranks, 1: doubled mean-centered ranks); write only while idle.
// Reset: arst_n clears the count, overflow flag, mode and controller; the
// sample store is not cleared, only entries written in a vector are read.
// Depends on vre_pkg, vre_ctrl, vre_dp and vre_ram.
module vector_rank_engine #(
	parameter int MAX_ITEMS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [vre_pkg::SAMPLE_W-1:0] sample,
	input  logic                               last,
	input  logic                               cfg_we,
	input  logic                               cfg_data,
	output logic                               strobe,
	output logic signed [vre_pkg::RANK_W-1:0]   rank,
	output logic                               final_res,
	output logic                               overflow
);

	vre_pkg::vre_cmd_t  cmd;
	vre_pkg::vre_stat_t stat;

	vre_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	vre_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.rank      (rank),
		.final_res (final_res),
		.overflow  (overflow),
		.strobe    (strobe)
	);

endmodule

// ----- rtl/vre_checker.sv -----
// Port-level checks for the vector rank engine, bound to the top level.
// Depends only on the top level's ports.
module vre_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last,
	input logic strobe,
	input logic final_res
);

	// results are spaced by the compare sweep
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("back-to-back result strobes");

	// the final result releases the input side in the same cycle
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && final_res |-> !busy)
		else $error("busy still high on final result");

	// results before the final one arrive while ranking continues
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !final_res |-> busy)
		else $error("busy low on a non-final result");

	// the last transaction starts ranking
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last |=> busy)
		else $error("busy not raised after last transaction");

	// loading never stalls the input
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last |=> !busy && !strobe)
		else $error("load transaction caused busy or a result");

endmodule

bind vector_rank_engine vre_checker u_vre_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.last      (last),
	.strobe    (strobe),
	.final_res (final_res)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for vector_rank_engine: a table of directed vectors, then random vectors.
// Ranks are checked by a stable-rank predictor in this file; typed rows by the table.
// Depends on vre_pkg and the vector_rank_engine RTL.
module testbench;

	localparam int CAPACITY      = 32;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_ITEMS  = 200;
	localparam int SETTLE_CYCLES = 40;
	localparam int CFG_KEEP      = -1;
	localparam int MODE_PLAIN    = 0;
	localparam int MODE_CENTERED = 1;

	typedef logic signed [vre_pkg::SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic signed [vre_pkg::RANK_W-1:0] rank;
		logic                              final_res;
		logic                              overflow;
	} rank_result_t;

	typedef struct {
		int           cfg;
		sample_t      smp;
		bit           lst;
		bit           typed;
		rank_result_t res;
	} stim_row_t;

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    start     = 1'b0;
	sample_t sample    = '0;
	logic    last      = 1'b0;
	logic    cfg_we    = 1'b0;
	logic    cfg_data  = 1'b0;
	logic    busy;
	logic    strobe;
	logic signed [vre_pkg::RANK_W-1:0] rank;
	logic    final_res;
	logic    overflow;

	// predictor state
	sample_t sample_mem [CAPACITY];
	int      fill_cnt;
	bit      drop_flag;
	bit      centered_mode;

	rank_result_t rank_expect_q [$];
	rank_result_t want;
	stim_row_t    stim_tbl [$];

	int err_cnt;
	int cycle_cnt;
	int sent_cnt;
	int vector_cnt;
	int checked_cnt;
	int ovf_vectors;
	int burst_left;

	vector_rank_engine #(
		.MAX_ITEMS(CAPACITY)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.sample   (sample),
		.last     (last),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.strobe   (strobe),
		.rank     (rank),
		.final_res(final_res),
		.overflow (overflow)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("[vector_rank_engine] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (strobe) begin
			if (rank_expect_q.size() == 0) begin
				$error("unexpected result: rank %0d final_res %0b overflow %0b",
					rank, final_res, overflow);
				err_cnt++;
			end else begin
				want = rank_expect_q.pop_front();
				checked_cnt++;
				if (rank !== want.rank) begin
					$error("rank: expected %0d, got %0d", want.rank, rank);
					err_cnt++;
				end
				if (final_res !== want.final_res) begin
					$error("final_res: expected %0b, got %0b", want.final_res, final_res);
					err_cnt++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, overflow);
					err_cnt++;
				end
			end
		end
	end

	// Store one accepted sample; on last, rank every stored sample in input order.
	function automatic void take_sample(sample_t s, bit l, bit push);
		int i;
		int j;
		int r;
		int val;
		rank_result_t res;
		if (fill_cnt < CAPACITY) begin
			sample_mem[fill_cnt] = s;
			fill_cnt++;
		end else begin
			drop_flag = 1'b1;
		end
		if (l) begin
			for (i = 0; i < fill_cnt; i++) begin
				r = 0;
				// ties go to the earlier sample
				for (j = 0; j < fill_cnt; j++)
					if (sample_mem[j] < sample_mem[i] ||
						(sample_mem[j] == sample_mem[i] && j < i))
						r++;
				val = centered_mode ? 2 * r - (fill_cnt - 1) : r + 1;
				res.rank      = val[vre_pkg::RANK_W-1:0];
				res.final_res = (i == fill_cnt - 1);
				res.overflow  = drop_flag;
				if (push)
					rank_expect_q.push_back(res);
			end
			fill_cnt  = 0;
			drop_flag = 1'b0;
			vector_cnt++;
		end
	endfunction

	function automatic void add_row(int cfg, sample_t smp, bit lst, bit typed = 1'b0,
		logic signed [vre_pkg::RANK_W-1:0] t_rank = '0);
		stim_row_t row;
		row.cfg           = cfg;
		row.smp           = smp;
		row.lst           = lst;
		row.typed         = typed;
		row.res.rank      = t_rank;
		row.res.final_res = 1'b1;
		row.res.overflow  = 1'b0;
		stim_tbl.push_back(row);
	endfunction

	// Hold the transaction until busy is low at an edge.
	task automatic send_sample(sample_t s, bit l, bit typed, rank_result_t typed_res);
		start  <= 1'b1;
		sample <= s;
		last   <= l;
		do
			@(posedge clk);
		while (busy);
		sent_cnt++;
		take_sample(s, l, !typed);
		if (typed)
			rank_expect_q.push_back(typed_res);
	endtask

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
		end
	endtask

	// Write the mode only once the engine has drained.
	task automatic set_mode(int m);
		start <= 1'b0;
		while (rank_expect_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= m[0];
		@(posedge clk);
		centered_mode = m[0];
		cfg_we <= 1'b0;
	endtask

	function automatic sample_t rand_sample();
		int pick;
		int v;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return sample_t'(32'h8000_0000);
		if (pick == 1)
			return sample_t'(32'h7FFF_FFFF);
		if (pick <= 4) begin
			v = $urandom_range(0, 6);
			return sample_t'(v - 3);
		end
		return sample_t'($urandom());
	endfunction

	initial begin
		int k;
		int len;
		int vec_idx;
		int pick;
		rank_result_t none;

		none = '0;
		fill_cnt      = 0;
		drop_flag     = 1'b0;
		centered_mode = 1'b0;
		burst_left    = 0;

		add_row(CFG_KEEP,      32'sd0,          1'b1, 1'b1, 8'sd1);
		add_row(MODE_CENTERED, 32'h7FFF_FFFF,   1'b1, 1'b1, 8'sd0);
		add_row(MODE_PLAIN,    32'h8000_0000,   1'b1, 1'b1, 8'sd1);
		add_row(CFG_KEEP,      32'h7FFF_FFFF,   1'b0);
		add_row(CFG_KEEP,      32'h8000_0000,   1'b0);
		add_row(CFG_KEEP,      32'sd0,          1'b0);
		add_row(CFG_KEEP,      -32'sd1,         1'b0);
		add_row(CFG_KEEP,      32'sd1,          1'b1);
		for (k = 0; k < 4; k++)
			add_row(CFG_KEEP, 32'sd5, k == 3);
		add_row(MODE_CENTERED, 32'h8000_0000,   1'b0);
		add_row(CFG_KEEP,      32'h7FFF_FFFF,   1'b0);
		add_row(CFG_KEEP,      32'h8000_0000,   1'b1);
		add_row(CFG_KEEP,      32'sd3,          1'b0);
		add_row(CFG_KEEP,      32'sd3,          1'b0);
		add_row(CFG_KEEP,      -32'sd3,         1'b0);
		add_row(CFG_KEEP,      32'sd3,          1'b0);
		add_row(CFG_KEEP,      -32'sd3,         1'b1);
		add_row(MODE_PLAIN,    32'hAAAA_AAAA,   1'b0);
		add_row(CFG_KEEP,      32'h5555_5555,   1'b0);
		add_row(CFG_KEEP,      32'h0001_0000,   1'b1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (stim_tbl[r]) begin
			if (stim_tbl[r].cfg != CFG_KEEP)
				set_mode(stim_tbl[r].cfg);
			send_sample(stim_tbl[r].smp, stim_tbl[r].lst, stim_tbl[r].typed,
				stim_tbl[r].res);
			pace();
		end

		// random vectors: mostly short, some full, a few past capacity
		vec_idx = 0;
		while (sent_cnt < stim_tbl.size() + RANDOM_ITEMS) begin
			if (vec_idx == 0)
				len = CAPACITY + 1;
			else if (vec_idx == 1)
				len = CAPACITY;
			else begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					len = $urandom_range(1, 6);
				else if (pick < 92)
					len = $urandom_range(7, CAPACITY);
				else
					len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
			end
			if (len > CAPACITY)
				ovf_vectors++;
			if ($urandom_range(0, 3) == 0)
				set_mode($urandom_range(MODE_PLAIN, MODE_CENTERED));
			for (k = 0; k < len; k++) begin
				send_sample(rand_sample(), k == len - 1, 1'b0, none);
				pace();
			end
			vec_idx++;
		end

		start <= 1'b0;
		while (rank_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (rank_expect_q.size() != 0) begin
			$error("%0d expected ranks never arrived", rank_expect_q.size());
			err_cnt++;
		end

		$display("Covered %0d samples in %0d vectors (%0d past capacity), %0d ranks checked,",
			sent_cnt, vector_cnt, ovf_vectors, checked_cnt);
		$display("in plain and centered modes, with ties and extreme samples.");
		if (err_cnt == 0)
			$display("[vector_rank_engine] OK");
		else
			$display("[vector_rank_engine] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/vre_pkg.sv
rtl/vre_ram.sv
rtl/vre_ctrl.sv
rtl/vre_dp.sv
rtl/vector_rank_engine.sv
rtl/vre_checker.sv
sim/testbench.sv
